FILE: rtl/oust_pkg.sv
package oust_pkg;

  localparam int unsigned CAPACITY   = 16;
  localparam int unsigned VALUE_BITS = 32;

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_ERASE  = 2'd1,
    ACT_QUERY  = 2'd2,
    ACT_CLEAR  = 2'd3
  } oust_action_e;

  typedef struct packed {
    oust_action_e       action;
    logic signed [31:0] value;
  } oust_in_t;

  typedef struct packed {
    logic       found;
    logic [4:0] count_after;
    logic       full_reject;
  } oust_out_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic shift;
    logic emit;
  } oust_cmd_t;

  typedef struct packed {
    logic in_clear;
    logic count_zero;
    logic act_erase;
    logic match;
    logic scan_last;
    logic shift_last;
    logic out_free;
  } oust_sts_t;

endpackage

FILE: rtl/oust_ctrl.sv
module oust_ctrl import oust_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  oust_sts_t sts_i,
  output oust_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_SHIFT = 4'b0100,
    ST_EMIT  = 4'b1000
  } oust_state_e;

  oust_state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (sts_i.in_clear || sts_i.count_zero) begin
            state_d = ST_EMIT;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.match) begin
          if (sts_i.act_erase && !sts_i.scan_last) begin
            state_d = ST_SHIFT;
          end else begin
            state_d = ST_EMIT;
          end
        end else if (sts_i.scan_last) begin
          state_d = ST_EMIT;
        end
      end
      ST_SHIFT: begin
        cmd_o.shift = 1'b1;
        if (sts_i.shift_last) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/oust_dpath.sv
module oust_dpath import oust_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  oust_in_t  in_data_i,
  input  oust_cmd_t cmd_i,
  output oust_sts_t sts_o,
  input  logic      out_ready_i,
  output logic      out_valid_o,
  output oust_out_t out_data_o
);

  logic [VALUE_BITS-1:0] mem [CAPACITY];
  logic [VALUE_BITS-1:0] rdata_q;
  logic [IDX_W-1:0]      rd_addr;

  oust_action_e          act_q;
  logic [VALUE_BITS-1:0] key_q;
  logic [IDX_W-1:0]      idx_q;
  logic                  found_q;
  logic [CNT_W-1:0]      count_q, count_d;
  logic                  out_valid_q;
  oust_out_t             out_q;

  logic [31:0]           value_u;
  logic [VALUE_BITS-1:0] key_in;
  logic [CNT_W:0]        idx_w, cnt_w;
  logic                  full;
  logic                  reject;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [VALUE_BITS-1:0] wr_data;
  logic [CNT_W+4:0]      count_ext;

  assign value_u = in_data_i.value;
  assign key_in  = VALUE_BITS'(value_u);
  assign idx_w   = (CNT_W + 1)'(idx_q);
  assign cnt_w   = (CNT_W + 1)'(count_q);
  assign full    = (cnt_w == (CNT_W + 1)'(CAPACITY));

  assign sts_o.in_clear   = (in_data_i.action == ACT_CLEAR);
  assign sts_o.count_zero = (count_q == '0);
  assign sts_o.act_erase  = (act_q == ACT_ERASE);
  assign sts_o.match      = (rdata_q == key_q);
  assign sts_o.scan_last  = ((idx_w + (CNT_W + 1)'(1)) == cnt_w);
  assign sts_o.shift_last = ((idx_w + (CNT_W + 1)'(2)) == cnt_w);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    if (cmd_i.load) begin
      rd_addr = '0;
    end else if (cmd_i.shift) begin
      rd_addr = idx_q + IDX_W'(2);
    end else begin
      rd_addr = idx_q + IDX_W'(1);
    end
  end

  always_comb begin
    count_d = count_q;
    reject  = 1'b0;
    wr_en   = 1'b0;
    wr_addr = idx_q;
    wr_data = rdata_q;
    if (cmd_i.shift) begin
      wr_en = 1'b1;
    end
    if (cmd_i.emit) begin
      case (act_q)
        ACT_CLEAR: begin
          count_d = '0;
        end
        ACT_INSERT: begin
          if (!found_q) begin
            if (full) begin
              reject = 1'b1;
            end else begin
              wr_en   = 1'b1;
              wr_addr = count_q[IDX_W-1:0];
              wr_data = key_q;
              count_d = count_q + CNT_W'(1);
            end
          end
        end
        ACT_ERASE: begin
          if (found_q) begin
            count_d = count_q - CNT_W'(1);
          end
        end
        default: begin
          count_d = count_q;
        end
      endcase
    end
  end

  assign count_ext = (CNT_W + 5)'(count_d);

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[rd_addr];
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q <= in_data_i.action;
      key_q <= key_in;
      idx_q <= '0;
    end else if ((cmd_i.scan && !sts_o.match) || cmd_i.shift) begin
      idx_q <= idx_q + IDX_W'(1);
    end
    if (cmd_i.emit) begin
      out_q.found       <= found_q;
      out_q.count_after <= count_ext[4:0];
      out_q.full_reject <= reject;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (cmd_i.load) begin
        found_q <= 1'b0;
      end else if (cmd_i.scan && sts_o.match) begin
        found_q <= 1'b1;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_w <= (CNT_W + 1)'(CAPACITY))
    else $error("held count exceeds capacity");

  a_shift_erase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.shift |-> (act_q == ACT_ERASE) && found_q)
    else $error("entries shifted outside an erase");

  a_reject_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && reject) |=> (count_q == $past(count_q)) && full)
    else $error("rejected insert changed the count");

  a_found_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.found && out_q.full_reject))
    else $error("result both found and rejected");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> sts_o.out_free)
    else $error("result overwritten before it was taken");
`endif

endmodule

FILE: rtl/ordered_unique_set_table_top.sv
// Channel | Direction | Handshake              | Beat
// in      | input     | in_valid_i / in_ready_o | in_data_i  (action, value)
// out     | output    | out_valid_o / out_ready_i | out_data_o (found, count_after, full_reject)
//
// One item is handled at a time; in_ready_o is high only while the controller is idle.
// Clear, or any operation on an empty set, goes from accept straight to its result step.
// Other items first scan the table, comparing entries (up to the held count) until a match;
// an erase that matches before the last entry then moves the later entries down one place.
// The result sits in an output register, so the next item is accepted while it waits;
// a stalled output holds the following item in its result step. Reset empties the set.
module ordered_unique_set_table_top import oust_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  oust_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output oust_out_t out_data_o
);

  oust_cmd_t cmd;
  oust_sts_t sts;

  oust_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  oust_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule
